FILE: hdl/tnc_pkg.sv
// ----------------------------------------------------------------------------
// Tensor name classifier package
// Pattern table, category codes, marker phases and the window matcher.
// ----------------------------------------------------------------------------
package tnc_pkg;

	localparam int WIN_DEPTH = 11;
	localparam int NUM_PATS  = 22;
	localparam int PAT_CHARS = WIN_DEPTH + 1;
	localparam int PAT_BITS  = PAT_CHARS * 8;

	typedef logic [WIN_DEPTH-1:0][7:0] win_t;
	typedef logic [PAT_BITS-1:0]       pat_text_t;
	typedef logic [3:0]                pat_len_t;
	typedef logic [NUM_PATS-1:0]       hits_t;

	typedef enum logic [3:0] {
		CAT_EMBED    = 4'd0,
		CAT_ATTN_Q   = 4'd1,
		CAT_ATTN_K   = 4'd2,
		CAT_ATTN_V   = 4'd3,
		CAT_ATTN_O   = 4'd4,
		CAT_FFN_GATE = 4'd5,
		CAT_FFN_UP   = 4'd6,
		CAT_FFN_DOWN = 4'd7,
		CAT_NORM     = 4'd8,
		CAT_OUTPUT   = 4'd9,
		CAT_MISC     = 4'd10
	} cat_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_DIGITS = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	// Strings are right aligned: the final character sits in the low byte.
	localparam pat_text_t PAT_TEXT [NUM_PATS] = '{
		"embed", "tok_emb",
		"attn_q", {"self_", "attn.q"},
		"attn_k", {"self_", "attn.k"},
		"attn_v", {"self_", "attn.v"},
		{"attn_", "output"}, {"self_", "attn.o"},
		{"ffn_", "gate"}, "mlp.gate",
		"ffn_up", "mlp.up",
		{"ffn_", "down"}, "mlp.down",
		"norm", "ln_", "rms",
		"output", "lm_head", {"embed_", "tokens"}
	};

	localparam pat_len_t PAT_LEN [NUM_PATS] = '{
		4'd5, 4'd7, 4'd6, 4'd11, 4'd6, 4'd11, 4'd6, 4'd11, 4'd11, 4'd11,
		4'd8, 4'd8, 4'd6, 4'd6, 4'd8, 4'd8, 4'd4, 4'd3, 4'd3, 4'd6,
		4'd7, 4'd12
	};

	localparam cat_t PAT_CAT [NUM_PATS] = '{
		CAT_EMBED, CAT_EMBED, CAT_ATTN_Q, CAT_ATTN_Q, CAT_ATTN_K, CAT_ATTN_K,
		CAT_ATTN_V, CAT_ATTN_V, CAT_ATTN_O, CAT_ATTN_O, CAT_FFN_GATE,
		CAT_FFN_GATE, CAT_FFN_UP, CAT_FFN_UP, CAT_FFN_DOWN, CAT_FFN_DOWN,
		CAT_NORM, CAT_NORM, CAT_NORM, CAT_OUTPUT, CAT_OUTPUT, CAT_OUTPUT
	};

	localparam pat_text_t MARK_BLK    = "blk.";
	localparam pat_len_t  MARK_BLK_LEN    = 4'd4;
	localparam pat_text_t MARK_LAYERS = "layers.";
	localparam pat_len_t  MARK_LAYERS_LEN = 4'd7;

	// True when the pattern ends on the current byte, the older bytes
	// lying in the window with the newest at entry zero.
	function automatic logic pat_end(input pat_text_t text, input pat_len_t len,
			input logic [7:0] c, input win_t w);
		logic ok;
		ok = (len != '0) && (text[7:0] == c);
		for (int j = 0; j < WIN_DEPTH; j++) begin
			if ((j + 1) < int'(len) && w[j] != text[8*(j+1) +: 8]) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

	// The lowest numbered pattern seen decides the category.
	function automatic cat_t pick_cat(input hits_t hits);
		cat_t cat;
		cat = CAT_MISC;
		for (int k = NUM_PATS - 1; k >= 0; k--) begin
			if (hits[k]) begin
				cat = PAT_CAT[k];
			end
		end
		return cat;
	endfunction

endpackage

FILE: hdl/tnc_match.sv
// ----------------------------------------------------------------------------
// Tensor name classifier pattern matcher
// Compares every fixed pattern against the current byte and the window.
// ----------------------------------------------------------------------------
module tnc_match (
	input  logic [7:0]    ch,
	input  tnc_pkg::win_t window,
	output tnc_pkg::hits_t hits
);
	import tnc_pkg::*;

	always_comb begin
		for (int k = 0; k < NUM_PATS; k++) begin
			hits[k] = pat_end(PAT_TEXT[k], PAT_LEN[k], ch, window);
		end
	end

endmodule

FILE: hdl/tnc_marker.sv
// ----------------------------------------------------------------------------
// Tensor name classifier marker tracker
// Watches for the first occurrence of a marker and accumulates the decimal
// number that follows it, saturating at the top of the layer range.
// ----------------------------------------------------------------------------
module tnc_marker #(
	parameter int LAYER_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  clear,
	input  tnc_pkg::pat_text_t    marker,
	input  tnc_pkg::pat_len_t     marker_len,
	input  logic [7:0]            ch,
	input  tnc_pkg::win_t         window,
	output logic                  seen_next,
	output logic [LAYER_BITS-1:0] num_next
);
	import tnc_pkg::*;

	phase_t                phase_q;
	phase_t                phase_d;
	logic [LAYER_BITS-1:0] num_q;
	logic                  is_digit;
	logic [3:0]            digit;
	logic [LAYER_BITS+3:0] prod;
	logic [LAYER_BITS+3:0] acc;

	assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
	assign digit    = 4'(ch - 8'h30);
	assign prod     = {1'b0, num_q, 3'b000} + {3'b000, num_q, 1'b0};
	assign acc      = prod + {{LAYER_BITS{1'b0}}, digit};

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (pat_end(marker, marker_len, ch, window)) begin
					phase_d = PH_DIGITS;
				end
			end
			PH_DIGITS: begin
				if (!is_digit) begin
					phase_d = PH_DONE;
				end
			end
			PH_DONE: phase_d = PH_DONE;
			default: phase_d = PH_IDLE;
		endcase
	end

	// Outputs: the number after this byte and whether the marker is known.
	always_comb begin
		seen_next = (phase_d != PH_IDLE);
		num_next  = num_q;
		if (phase_q == PH_DIGITS && is_digit) begin
			if (acc[LAYER_BITS+3:LAYER_BITS] != '0) begin
				num_next = '1;
			end else begin
				num_next = acc[LAYER_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			num_q   <= '0;
		end else if (step) begin
			if (clear) begin
				phase_q <= PH_IDLE;
				num_q   <= '0;
			end else begin
				phase_q <= phase_d;
				num_q   <= num_next;
			end
		end
	end

endmodule

FILE: hdl/tensor_name_classifier.sv
// ----------------------------------------------------------------------------
// Tensor name classifier
// Sorts tensor names, given one byte per request, into eleven categories.
// ----------------------------------------------------------------------------
// The block takes one byte of a tensor name per cycle while in_stall is
// low, with last high on the final byte, and gives one result per name: the
// category (0 embedding, 1 to 4 attention q, k, v, o, 5 to 7 feed-forward
// gate, up, down, 8 norm, 9 output, 10 misc) and a signed layer number, -1
// where no "blk." or "layers." marker was seen or the category carries no
// layer. Each accepted byte passes through an input register and then
// through one stage in which the window comparators and the decimal
// accumulators update the name state and the result buffer is loaded. A
// two-entry result buffer lets bytes keep arriving while a result waits;
// in_stall rises only when the skid entry is in use, or when a result is
// being formed while the one in the output register is held by out_stall.
// Names must be at least one byte long, and every state register is cleared
// once a name completes.
module tensor_name_classifier #(
	parameter int LAYER_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         ch,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         category,
	output logic signed [16:0] layer
);
	import tnc_pkg::*;

	// Input register.
	logic       in_valid_s1;
	logic [7:0] ch_s1;
	logic       last_s1;

	// Name state.
	win_t  window_q;
	hits_t hits_q;
	hits_t hits_now;
	hits_t hits_next;

	logic                  blk_seen;
	logic [LAYER_BITS-1:0] blk_num;
	logic                  lay_seen;
	logic [LAYER_BITS-1:0] lay_num;

	// Result buffer: the output register and a skid entry behind it.
	logic               out_valid_q;
	logic [3:0]         cat_q;
	logic signed [16:0] layer_q;
	logic               skid_valid_q;
	logic [3:0]         skid_cat_q;
	logic signed [16:0] skid_layer_q;

	logic               in_take;
	logic               res_write;
	logic               out_pop;
	cat_t               res_cat;
	logic signed [16:0] res_layer;
	logic [LAYER_BITS+16:0] blk_ext;
	logic [LAYER_BITS+16:0] lay_ext;

	// The stall rises when the skid entry is taken, or when a result is
	// about to be formed while the waiting one is held back this cycle, so
	// that a byte let in now can never find the buffer full.
	assign in_stall = skid_valid_q || (out_valid_q && out_stall && in_valid_s1 && last_s1);
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else begin
			in_valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	tnc_match u_match (
		.ch     (ch_s1),
		.window (window_q),
		.hits   (hits_now)
	);

	tnc_marker #(
		.LAYER_BITS (LAYER_BITS)
	) u_blk (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (in_valid_s1),
		.clear      (last_s1),
		.marker     (MARK_BLK),
		.marker_len (MARK_BLK_LEN),
		.ch         (ch_s1),
		.window     (window_q),
		.seen_next  (blk_seen),
		.num_next   (blk_num)
	);

	tnc_marker #(
		.LAYER_BITS (LAYER_BITS)
	) u_layers (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (in_valid_s1),
		.clear      (last_s1),
		.marker     (MARK_LAYERS),
		.marker_len (MARK_LAYERS_LEN),
		.ch         (ch_s1),
		.window     (window_q),
		.seen_next  (lay_seen),
		.num_next   (lay_num)
	);

	assign hits_next = hits_q | hits_now;

	// The window shifts by one byte per step and is emptied with the hit
	// bits once the final byte has been counted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			hits_q   <= '0;
		end else if (in_valid_s1) begin
			if (last_s1) begin
				window_q <= '0;
				hits_q   <= '0;
			end else begin
				window_q <= {window_q[WIN_DEPTH-2:0], ch_s1};
				hits_q   <= hits_next;
			end
		end
	end

	// Result of the name that ends on the byte in stage one. Only the low
	// seventeen bits of a captured number reach the layer field.
	assign res_cat = pick_cat(hits_next);
	assign blk_ext = {17'd0, blk_num};
	assign lay_ext = {17'd0, lay_num};

	always_comb begin
		res_layer = '1;
		if (res_cat != CAT_EMBED && res_cat != CAT_OUTPUT && res_cat != CAT_MISC) begin
			priority if (blk_seen) begin
				res_layer = blk_ext[16:0];
			end else if (lay_seen) begin
				res_layer = lay_ext[16:0];
			end else begin
				res_layer = '1;
			end
		end
	end

	assign res_write = in_valid_s1 && last_s1;
	assign out_pop   = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_pop) begin
				if (res_write) begin
					skid_valid_q <= 1'b1;
				end
			end else if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= res_write;
			end else begin
				out_valid_q <= res_write;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && !out_pop) begin
			if (res_write) begin
				skid_cat_q   <= 4'(res_cat);
				skid_layer_q <= res_layer;
			end
		end else if (skid_valid_q) begin
			cat_q   <= skid_cat_q;
			layer_q <= skid_layer_q;
			if (res_write) begin
				skid_cat_q   <= 4'(res_cat);
				skid_layer_q <= res_layer;
			end
		end else if (res_write) begin
			cat_q   <= 4'(res_cat);
			layer_q <= res_layer;
		end
	end

	assign out_valid = out_valid_q;
	assign category  = cat_q;
	assign layer     = layer_q;

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Tensor name classifier testbench
// Feeds tensor names byte by byte and checks each category and layer result.
// ----------------------------------------------------------------------------
// An initial block builds the whole byte stream. It starts with a short set of
// hand-picked names, then adds random names until about four hundred bytes
// are queued. Most of the random names follow the usual naming shapes (a
// layer marker, a number, a role, a suffix). The rest are loose fragments
// and raw random bytes.
//
// A clocked driver offers the queued bytes in bursts with gaps between them.
// When a request is accepted, the driver passes its byte through a predictor.
// The predictor keeps its own byte window, pattern flags and layer number
// trackers. On the final byte of a name it queues the expected category and
// layer.
//
// A clocked monitor compares each accepted result with the oldest
// expectation. The receiver switches between stall patterns as the run
// goes on. Now and then it holds off for a long stretch so that the block
// backs up and stalls its input.
module testbench;
	import tnc_pkg::*;

	localparam int          LAYER_BITS = 16;
	localparam longint      LAYER_CAP  = (64'd1 << LAYER_BITS) - 1;
	localparam int          HOLD_LEN   = 90;
	localparam int          DRAIN_WAIT = 10;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} name_byte_t;

	typedef struct {
		cat_t        category;
		logic [16:0] layer;
	} class_result_t;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic [7:0]         ch        = 8'h00;
	logic               last      = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [3:0]         category;
	logic signed [16:0] layer;

	tensor_name_classifier #(
		.LAYER_BITS(LAYER_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.ch       (ch),
		.last     (last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.category (category),
		.layer    (layer)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Bytes that are waiting to be offered, and results that are expected.
	name_byte_t    pending_bytes [$];
	class_result_t expected_results [$];
	int            mismatches = 0;

	// The predictor's copy of the state for the name that is in progress.
	logic [7:0]    name_win [WIN_DEPTH];
	logic [21:0]   seen_pats;
	phase_t        blk_ph;
	phase_t        layers_ph;
	int unsigned   blk_num;
	int unsigned   layers_num;

	// Sender burst and gap counters, and receiver stall control.
	int            burst_left = 0;
	int            gap_left   = 0;
	int            hold_left  = 0;
	int            rx_cycle   = 0;
	int            stall_mode = 0;

	// The substrings that are searched for, in priority order. The lowest
	// index that was seen anywhere in the name decides the category.
	function automatic string name_pattern(input int k);
		case (k)
			0:       return "embed";
			1:       return "tok_emb";
			2:       return "attn_q";
			3:       return {string'("self_"), "attn.q"};
			4:       return "attn_k";
			5:       return {string'("self_"), "attn.k"};
			6:       return "attn_v";
			7:       return {string'("self_"), "attn.v"};
			8:       return {string'("attn_"), "output"};
			9:       return {string'("self_"), "attn.o"};
			10:      return {string'("ffn_"), "gate"};
			11:      return "mlp.gate";
			12:      return "ffn_up";
			13:      return "mlp.up";
			14:      return {string'("ffn_"), "down"};
			15:      return "mlp.down";
			16:      return "norm";
			17:      return "ln_";
			18:      return "rms";
			19:      return "output";
			20:      return "lm_head";
			default: return {string'("embed_"), "tokens"};
		endcase
	endfunction

	function automatic cat_t pattern_class(input int k);
		case (k)
			0, 1:        return CAT_EMBED;
			2, 3:        return CAT_ATTN_Q;
			4, 5:        return CAT_ATTN_K;
			6, 7:        return CAT_ATTN_V;
			8, 9:        return CAT_ATTN_O;
			10, 11:      return CAT_FFN_GATE;
			12, 13:      return CAT_FFN_UP;
			14, 15:      return CAT_FFN_DOWN;
			16, 17, 18:  return CAT_NORM;
			default:     return CAT_OUTPUT;
		endcase
	endfunction

	// True when the text ends on byte c, with the earlier bytes of the text
	// sitting in the window, the newest byte at entry zero.
	function automatic bit ends_on(input string p, input logic [7:0] c);
		int n;
		n = p.len();
		if (n == 0 || n > WIN_DEPTH + 1) begin
			return 1'b0;
		end
		if (p[n-1] != c) begin
			return 1'b0;
		end
		for (int k = 0; k < n - 1; k++) begin
			if (name_win[k] != p[n-2-k]) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// Layer number capture after a marker. Digits accumulate and saturate.
	// The first non-digit closes the number. Only the first marker counts,
	// because the phase never goes back to idle within a name.
	task automatic step_marker(input string mark, input logic [7:0] c,
			inout phase_t ph, inout int unsigned num);
		longint unsigned v;
		if (ph == PH_DIGITS) begin
			if (c >= "0" && c <= "9") begin
				v   = 64'(num) * 10 + 64'(c - "0");
				num = (v > LAYER_CAP) ? int'(LAYER_CAP) : int'(v);
			end else begin
				ph = PH_DONE;
			end
		end
		if (ph == PH_IDLE && ends_on(mark, c)) begin
			ph = PH_DIGITS;
		end
	endtask

	task automatic clear_name_state();
		for (int k = 0; k < WIN_DEPTH; k++) begin
			name_win[k] = 8'h00;
		end
		seen_pats  = '0;
		blk_ph     = PH_IDLE;
		layers_ph  = PH_IDLE;
		blk_num    = 0;
		layers_num = 0;
	endtask

	// Advances the predictor by one accepted byte. On the final byte it
	// queues the result and starts a fresh name.
	task automatic classify_byte(input logic [7:0] c, input logic fin);
		class_result_t res;
		bit            found;
		for (int k = 0; k < NUM_PATS; k++) begin
			if (ends_on(name_pattern(k), c)) begin
				seen_pats[k] = 1'b1;
			end
		end
		step_marker("blk.", c, blk_ph, blk_num);
		step_marker("layers.", c, layers_ph, layers_num);
		for (int k = WIN_DEPTH - 1; k > 0; k--) begin
			name_win[k] = name_win[k-1];
		end
		name_win[0] = c;
		if (fin) begin
			res.category = CAT_MISC;
			found        = 1'b0;
			for (int k = 0; k < NUM_PATS; k++) begin
				if (!found && seen_pats[k]) begin
					res.category = pattern_class(k);
					found        = 1'b1;
				end
			end
			// Only the attention, feed-forward and norm categories carry a layer.
			// The blk number wins over the layers number.
			res.layer = '1;
			if (res.category >= CAT_ATTN_Q && res.category <= CAT_NORM) begin
				if (blk_ph != PH_IDLE) begin
					res.layer = 17'(blk_num);
				end else if (layers_ph != PH_IDLE) begin
					res.layer = 17'(layers_num);
				end
			end
			expected_results.insert(expected_results.size(), res);
			clear_name_state();
		end
	endtask

	// Stimulus helpers.
	task automatic queue_name(input string s);
		for (int k = 0; k < s.len(); k++) begin
			pending_bytes.insert(pending_bytes.size(),
				name_byte_t'{ch: s[k], last: (k == s.len() - 1)});
		end
	endtask

	task automatic queue_raw_name(input int n);
		for (int k = 0; k < n; k++) begin
			pending_bytes.insert(pending_bytes.size(),
				name_byte_t'{ch: 8'($urandom_range(0, 255)), last: (k == n - 1)});
		end
	endtask

	// The digits after a marker. Sometimes there are none, sometimes the value
	// is near the saturation point, and sometimes it is far beyond it.
	function automatic string layer_digits();
		case ($urandom_range(0, 9))
			0:       return "";
			1:       return $sformatf("%0d", $urandom_range(65530, 65540));
			2:       return $sformatf("%0d%0d", $urandom(), $urandom_range(0, 9));
			default: return $sformatf("%0d", $urandom_range(0, 99));
		endcase
	endfunction

	function automatic string tensor_role();
		case ($urandom_range(0, 27))
			0:       return "attn_q";
			1:       return "attn_k";
			2:       return "attn_v";
			3:       return {string'("attn_"), "output"};
			4:       return "attn_norm";
			5:       return {string'("ffn_"), "gate"};
			6:       return "ffn_up";
			7:       return {string'("ffn_"), "down"};
			8:       return "ffn_norm";
			9:       return {string'("self_"), "attn.q_proj"};
			10:      return {string'("self_"), "attn.k_proj"};
			11:      return {string'("self_"), "attn.v_proj"};
			12:      return {string'("self_"), "attn.o_proj"};
			13:      return "mlp.gate_proj";
			14:      return "mlp.up_proj";
			15:      return "mlp.down_proj";
			16:      return "input_layernorm";
			17:      return "post_attention_layernorm";
			18:      return "ln_2";
			19:      return "rms_scale";
			20:      return "attn_qkv";
			21:      return {string'("ffn_"), "gate_exps"};
			22:      return "output";
			23:      return "lm_head";
			24:      return "token_embd";
			25:      return {string'("embed_"), "tokens"};
			26:      return "tok_embeddings";
			default: return "rope_freqs";
		endcase
	endfunction

	// Pieces that almost form patterns or markers. They are glued together
	// at random to build broken names.
	function automatic string loose_fragment();
		case ($urandom_range(0, 23))
			0:       return "blk";
			1:       return "blk.";
			2:       return "layers";
			3:       return "layers.";
			4:       return ".";
			5:       return "attn_";
			6:       return {string'("self_"), "attn."};
			7:       return "mlp.";
			8:       return "ffn_";
			9:       return "emb";
			10:      return "ed";
			11:      return "q";
			12:      return "o";
			13:      return "gate";
			14:      return "up";
			15:      return "down";
			16:      return "nor";
			17:      return "m";
			18:      return "rm";
			19:      return "s";
			20:      return "lm_";
			21:      return "head";
			22:      return "_";
			default: return $sformatf("%0d", $urandom_range(0, 999));
		endcase
	endfunction

	// Request driver: it holds a byte until the block takes it, then offers the
	// next one. It works in bursts of random length with idle gaps between.
	always @(posedge clk) begin : drive_requests
		logic       valid_nxt;
		logic [7:0] ch_nxt;
		logic       last_nxt;
		name_byte_t b;
		valid_nxt = in_valid;
		ch_nxt    = ch;
		last_nxt  = last;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				classify_byte(ch, last);
				valid_nxt = 1'b0;
			end
			if (!valid_nxt) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_bytes.size() > 0) begin
					b         = pending_bytes.pop_front();
					valid_nxt = 1'b1;
					ch_nxt    = b.ch;
					last_nxt  = b.last;
					if (burst_left > 0) begin
						burst_left--;
					end
					if (burst_left == 0) begin
						// A gap of zero gives long stretches with no idling.
						burst_left = $urandom_range(1, 48);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
					end
				end
			end
			in_valid <= valid_nxt;
			ch       <= ch_nxt;
			last     <= last_nxt;
		end
	end

	// Result receiver: it picks a new stall pattern at regular intervals.
	// A long hold-off early in the run, and further ones later, fill the
	// result buffer so that the block has to stall its input.
	always @(posedge clk) begin : stall_results
		logic stall_nxt;
		stall_nxt = 1'b0;
		if (arst_n) begin
			rx_cycle++;
			if (rx_cycle == 200 || rx_cycle % 1500 == 900) begin
				hold_left = HOLD_LEN;
			end
			if (rx_cycle % 40 == 0) begin
				stall_mode = $urandom_range(0, 3);
			end
			if (hold_left > 0) begin
				hold_left--;
				stall_nxt = 1'b1;
			end else begin
				case (stall_mode)
					0:       stall_nxt = 1'b0;
					1:       stall_nxt = 1'($urandom_range(0, 1));
					2:       stall_nxt = (rx_cycle % 4 != 0);
					default: stall_nxt = ($urandom_range(0, 4) == 0);
				endcase
			end
			out_stall <= stall_nxt;
		end
	end

	// Result monitor: each accepted result is checked against the oldest
	// expectation.
	always @(posedge clk) begin : check_results
		class_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: category %0d layer %0d", category, layer);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (category !== want.category) begin
					$error("category: expected %0d, got %0d", want.category, category);
					mismatches++;
				end
				if (layer !== want.layer) begin
					$error("layer: expected %0d, got %0d", $signed(want.layer), layer);
					mismatches++;
				end
			end
		end
	end

	initial begin : run_test
		int r;
		int parts;
		string s;
		clear_name_state();

		// Hand-picked names: every category, both markers, saturation, a
		// marker with no digits, repeated markers, a name that ends in a
		// digit, and names of one byte, including the zero byte and 0xff.
		queue_name("a");
		pending_bytes.insert(pending_bytes.size(), name_byte_t'{ch: 8'h00, last: 1'b1});
		pending_bytes.insert(pending_bytes.size(), name_byte_t'{ch: 8'hff, last: 1'b1});
		queue_name("tok_embeddings");
		queue_name("blk.0.attn_q");
		queue_name("blk.12.attn_k");
		queue_name({string'("layers.3.self_"), "attn.v_proj"});
		queue_name({string'("blk.4.attn_"), "output"});
		queue_name({string'("layers.5.self_"), "attn.o"});
		queue_name({string'("blk.6.ffn_"), "gate"});
		queue_name("layers.7.mlp.up");
		queue_name({string'("blk.8.ffn_"), "down"});
		queue_name("blk.9.attn_norm");
		queue_name("blk.99999999.ffn_up");
		queue_name("blk.x.rms");
		queue_name("layers.2.blk.31.ln_1");
		queue_name("blk.1.blk.2.attn_v");
		queue_name("layers.65535.norm");
		queue_name("layers.65536.norm");
		queue_name("output.weight");
		queue_name("lm_head");
		queue_name({string'("model.embed_"), "tokens"});
		queue_name("blk.3");
		queue_raw_name(14);

		// Random names, mostly well formed.
		while (pending_bytes.size() < 400) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				case ($urandom_range(0, 3))
					0:       s = {"blk.", layer_digits(), "."};
					1:       s = {"model.layers.", layer_digits(), "."};
					2:       s = {"layers.", layer_digits(), ".blk.", layer_digits(), "."};
					default: s = "";
				endcase
				s = {s, tensor_role()};
				case ($urandom_range(0, 2))
					0:       s = {s, ".weight"};
					1:       s = {s, ".bias"};
					default: s = s;
				endcase
				queue_name(s);
			end else if (r < 85) begin
				s     = "";
				parts = $urandom_range(1, 6);
				for (int k = 0; k < parts; k++) begin
					s = {s, loose_fragment()};
				end
				queue_name(s);
			end else begin
				queue_raw_name($urandom_range(1, 14));
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Hard limit on the run, far beyond the slowest correct run.
	initial begin : watchdog
		#(12 * 400000);
		$display("TB_ERROR");
		$finish;
	end

endmodule
